>>> rtl/dhd_pkg.sv
package dhd_pkg;

   localparam int MAX_DEGRADE_DEF = 4;
   localparam int MIN_FPS_X16_DEF = 240;

   localparam int FREEZE_W = 17;
   localparam int JITTER_W = 20;
   localparam int LOST_W   = 16;
   localparam int LOSS_W   = 7;
   localparam int FPS_W    = 14;
   localparam int RTT_W    = 20;
   localparam int LEVEL_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [LOSS_W-1:0] LOSS_CLAMP = 7'd100;

   // observed class and state codes
   localparam logic [1:0] ST_STABLE  = 2'd0;
   localparam logic [1:0] ST_WARN    = 2'd1;
   localparam logic [1:0] ST_CONG    = 2'd2;
   localparam logic [1:0] ST_RECOVER = 2'd3;

   // csr indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONG_FREEZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONG_LOSS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONG_JITTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONG_RTT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_FREEZE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_LOSS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_JITTER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_RTT    = 3'd7;

   typedef struct packed {
      logic [FREEZE_W-1:0] cong_freeze;
      logic [LOSS_W-1:0]   cong_loss;
      logic [JITTER_W-1:0] cong_jitter;
      logic [RTT_W-1:0]    cong_rtt;
      logic [FREEZE_W-1:0] warn_freeze;
      logic [LOSS_W-1:0]   warn_loss;
      logic [JITTER_W-1:0] warn_jitter;
      logic [RTT_W-1:0]    warn_rtt;
   } thresh_type;

   localparam thresh_type THRESH_RESET = '{
      cong_freeze: 17'd9830,
      cong_loss:   7'd10,
      cong_jitter: 20'd100000,
      cong_rtt:    20'd600000,
      warn_freeze: 17'd3277,
      warn_loss:   7'd2,
      warn_jitter: 20'd30000,
      warn_rtt:    20'd300000
   };

   typedef struct packed {
      logic [FREEZE_W-1:0] freeze;
      logic [JITTER_W-1:0] jitter;
      logic [LOSS_W-1:0]   loss;
      logic [FPS_W-1:0]    fps;
      logic                fps_seen;
   } stats_type;

   localparam stats_type STATS_CLEAR = '{
      freeze:   '0,
      jitter:   '0,
      loss:     '0,
      fps:      '1,
      fps_seen: 1'b0
   };

   typedef struct packed {
      logic [1:0]         state;
      logic [LEVEL_W-1:0] level;
      logic               changed;
   } fsm_out_type;

endpackage

>>> rtl/dhd_classify.sv
module dhd_classify #(
   parameter int MIN_FPS_X16 = dhd_pkg::MIN_FPS_X16_DEF
) (
   input  dhd_pkg::thresh_type              thresh,
   input  dhd_pkg::stats_type               stats,
   input  logic [dhd_pkg::RTT_W-1:0]        rtt,
   output logic [1:0]                       obs_class
);

   logic cong_hit;
   logic warn_hit;
   logic fps_low;

   always_comb begin
      cong_hit = (stats.freeze >= thresh.cong_freeze) || (stats.loss >= thresh.cong_loss) ||
                 (stats.jitter >= thresh.cong_jitter) || (rtt >= thresh.cong_rtt);
      fps_low  = stats.fps_seen && (stats.fps < dhd_pkg::FPS_W'(MIN_FPS_X16));
      warn_hit = (stats.freeze >= thresh.warn_freeze) || (stats.loss >= thresh.warn_loss) ||
                 (stats.jitter >= thresh.warn_jitter) || (rtt >= thresh.warn_rtt) || fps_low;
      if (cong_hit) begin
         obs_class = dhd_pkg::ST_CONG;
      end else if (warn_hit) begin
         obs_class = dhd_pkg::ST_WARN;
      end else begin
         obs_class = dhd_pkg::ST_STABLE;
      end
   end

endmodule

>>> rtl/dhd_health_fsm.sv
module dhd_health_fsm #(
   parameter int MAX_DEGRADE = dhd_pkg::MAX_DEGRADE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           obs_class,
   output dhd_pkg::fsm_out_type fsm_out
);

   localparam logic [dhd_pkg::LEVEL_W:0] LEVEL_MAX = (dhd_pkg::LEVEL_W+1)'(MAX_DEGRADE);

   logic [1:0]                  state_ff, state_in;
   logic [dhd_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [1:0]                  count_ff, count_in;
   logic [dhd_pkg::LEVEL_W:0]   sum1, sum2;
   logic [dhd_pkg::LEVEL_W-1:0] raise1, raise2, level_dec;
   logic [1:0]                  count_inc;

   always_comb begin
      sum1      = {1'b0, level_ff} + 1'b1;
      sum2      = {1'b0, level_ff} + 2'd2;
      raise1    = (sum1 > LEVEL_MAX) ? LEVEL_MAX[dhd_pkg::LEVEL_W-1:0]
                                     : sum1[dhd_pkg::LEVEL_W-1:0];
      raise2    = (sum2 > LEVEL_MAX) ? LEVEL_MAX[dhd_pkg::LEVEL_W-1:0]
                                     : sum2[dhd_pkg::LEVEL_W-1:0];
      level_dec = level_ff - 1'b1;
      count_inc = (count_ff == 2'd3) ? count_ff : count_ff + 1'b1;

      state_in = state_ff;
      level_in = level_ff;
      count_in = count_ff;
      unique case (state_ff)
         dhd_pkg::ST_STABLE: begin
            if (obs_class == dhd_pkg::ST_CONG) begin
               state_in = dhd_pkg::ST_CONG;
               level_in = raise2;
               count_in = 2'd0;
            end else if (obs_class == dhd_pkg::ST_WARN) begin
               state_in = dhd_pkg::ST_WARN;
               level_in = raise1;
               count_in = 2'd0;
            end
         end
         dhd_pkg::ST_WARN: begin
            if (obs_class == dhd_pkg::ST_CONG) begin
               state_in = dhd_pkg::ST_CONG;
               level_in = raise2;
               count_in = 2'd0;
            end else if (obs_class == dhd_pkg::ST_STABLE) begin
               state_in = dhd_pkg::ST_RECOVER;
               count_in = 2'd1;
            end
         end
         dhd_pkg::ST_CONG: begin
            if (obs_class == dhd_pkg::ST_CONG) begin
               level_in = raise1;
            end else begin
               state_in = dhd_pkg::ST_RECOVER;
               count_in = 2'd1;
            end
         end
         default: begin
            if (obs_class == dhd_pkg::ST_CONG) begin
               state_in = dhd_pkg::ST_CONG;
               level_in = raise2;
               count_in = 2'd0;
            end else if (obs_class == dhd_pkg::ST_STABLE) begin
               count_in = count_inc;
               if (count_inc == 2'd3 && level_ff != '0) begin
                  level_in = level_dec;
                  count_in = 2'd0;
                  if (level_dec == '0) begin
                     state_in = dhd_pkg::ST_STABLE;
                  end
               end
            end else begin
               count_in = 2'd0;
            end
         end
      endcase

      fsm_out.state   = state_in;
      fsm_out.level   = level_in;
      fsm_out.changed = (level_in != level_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhd_pkg::ST_STABLE;
         level_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/downlink_health_degrade_fsm_top.sv
// A result reaches the output register after its last beat is accepted: input register,
// then aggregate/classify/state step into the output register once that register is free.
// Throughput: one beat per cycle; a last beat holds the input register only while an
// earlier result waits on stall, other beats keep flowing.
// Reset (synchronous, active high): thresholds return to defaults, aggregates clear,
// state machine returns to stable with degrade level and stable count at zero.
module downlink_health_degrade_fsm_top #(
   parameter int MAX_DEGRADE = dhd_pkg::MAX_DEGRADE_DEF,
   parameter int MIN_FPS_X16 = dhd_pkg::MIN_FPS_X16_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_we,
   input  logic [dhd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dhd_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_visible,
   input  logic [dhd_pkg::FREEZE_W-1:0]     req_freeze_rate,
   input  logic [dhd_pkg::JITTER_W-1:0]     req_jitter_us,
   input  logic [dhd_pkg::LOST_W-1:0]       req_packets_lost,
   input  logic [dhd_pkg::FPS_W-1:0]        req_frame_rate,
   input  logic [dhd_pkg::RTT_W-1:0]        req_round_trip_us,
   input  logic                             req_last_of_snapshot,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_observed_class,
   output logic [1:0]                       rsp_health_state,
   output logic [dhd_pkg::LEVEL_W-1:0]      rsp_degrade_value,
   output logic                             rsp_level_changed
);

   dhd_pkg::thresh_type thresh_ff;
   dhd_pkg::stats_type  agg_ff, agg_in, merged;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_visible_ff;
   logic [dhd_pkg::FREEZE_W-1:0] s1_freeze_ff;
   logic [dhd_pkg::JITTER_W-1:0] s1_jitter_ff;
   logic [dhd_pkg::LOST_W-1:0]   s1_lost_ff;
   logic [dhd_pkg::FPS_W-1:0]    s1_fps_ff;
   logic [dhd_pkg::RTT_W-1:0]    s1_rtt_ff;
   logic                         s1_last_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_class_ff;
   logic [1:0]                   rsp_state_ff;
   logic [dhd_pkg::LEVEL_W-1:0]  rsp_level_ff;
   logic                         rsp_changed_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         advance;
   logic                         step;
   logic [dhd_pkg::LOSS_W-1:0]   loss_clamped;
   logic [1:0]                   obs_class;
   dhd_pkg::fsm_out_type         fsm_out;

   // thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= dhd_pkg::THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dhd_pkg::CSR_CONG_FREEZE: thresh_ff.cong_freeze <= csr_wdata[dhd_pkg::FREEZE_W-1:0];
            dhd_pkg::CSR_CONG_LOSS:   thresh_ff.cong_loss   <= csr_wdata[dhd_pkg::LOSS_W-1:0];
            dhd_pkg::CSR_CONG_JITTER: thresh_ff.cong_jitter <= csr_wdata[dhd_pkg::JITTER_W-1:0];
            dhd_pkg::CSR_CONG_RTT:    thresh_ff.cong_rtt    <= csr_wdata[dhd_pkg::RTT_W-1:0];
            dhd_pkg::CSR_WARN_FREEZE: thresh_ff.warn_freeze <= csr_wdata[dhd_pkg::FREEZE_W-1:0];
            dhd_pkg::CSR_WARN_LOSS:   thresh_ff.warn_loss   <= csr_wdata[dhd_pkg::LOSS_W-1:0];
            dhd_pkg::CSR_WARN_JITTER: thresh_ff.warn_jitter <= csr_wdata[dhd_pkg::JITTER_W-1:0];
            default:                  thresh_ff.warn_rtt    <= csr_wdata[dhd_pkg::RTT_W-1:0];
         endcase
      end
   end

   // flow control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign step       = advance && s1_last_ff;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_visible_ff <= req_visible;
         s1_freeze_ff  <= req_freeze_rate;
         s1_jitter_ff  <= req_jitter_us;
         s1_lost_ff    <= req_packets_lost;
         s1_fps_ff     <= req_frame_rate;
         s1_rtt_ff     <= req_round_trip_us;
         s1_last_ff    <= req_last_of_snapshot;
      end
   end

   // running aggregates with the staged beat folded in
   always_comb begin
      loss_clamped = (s1_lost_ff > dhd_pkg::LOST_W'(dhd_pkg::LOSS_CLAMP))
                   ? dhd_pkg::LOSS_CLAMP : s1_lost_ff[dhd_pkg::LOSS_W-1:0];
      merged = agg_ff;
      if (s1_visible_ff) begin
         if (s1_freeze_ff > agg_ff.freeze) begin
            merged.freeze = s1_freeze_ff;
         end
         if (s1_jitter_ff > agg_ff.jitter) begin
            merged.jitter = s1_jitter_ff;
         end
         if (loss_clamped > agg_ff.loss) begin
            merged.loss = loss_clamped;
         end
         if (s1_fps_ff != '0) begin
            if (!agg_ff.fps_seen || s1_fps_ff < agg_ff.fps) begin
               merged.fps = s1_fps_ff;
            end
            merged.fps_seen = 1'b1;
         end
      end
      agg_in = s1_last_ff ? dhd_pkg::STATS_CLEAR : merged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_ff <= dhd_pkg::STATS_CLEAR;
      end else if (advance) begin
         agg_ff <= agg_in;
      end
   end

   dhd_classify #(
      .MIN_FPS_X16 (MIN_FPS_X16)
   ) u_classify (
      .thresh    (thresh_ff),
      .stats     (merged),
      .rtt       (s1_rtt_ff),
      .obs_class (obs_class)
   );

   dhd_health_fsm #(
      .MAX_DEGRADE (MAX_DEGRADE)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .obs_class (obs_class),
      .fsm_out   (fsm_out)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_class_ff   <= obs_class;
         rsp_state_ff   <= fsm_out.state;
         rsp_level_ff   <= fsm_out.level;
         rsp_changed_ff <= fsm_out.changed;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_observed_class = rsp_class_ff;
   assign rsp_health_state   = rsp_state_ff;
   assign rsp_degrade_value  = rsp_level_ff;
   assign rsp_level_changed  = rsp_changed_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_level_ff} <= (dhd_pkg::LEVEL_W+1)'(MAX_DEGRADE)))
      else $error("degrade level above maximum");

   a_stable_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_state_ff == dhd_pkg::ST_STABLE) |-> (rsp_level_ff == '0))
      else $error("stable state with nonzero degrade level");

   a_cong_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff == dhd_pkg::ST_CONG) |-> (rsp_state_ff == dhd_pkg::ST_CONG))
      else $error("congested observation did not enter congested state");

   a_cong_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff == dhd_pkg::ST_CONG && !rsp_changed_ff)
      |-> ({1'b0, rsp_level_ff} == (dhd_pkg::LEVEL_W+1)'(MAX_DEGRADE)))
      else $error("congested beat left unsaturated level unchanged");

   a_step_slot: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("classified snapshot not presented");

endmodule
